@@ design/lomuto_quicksort_by_key_unit_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef LOMUTO_QUICKSORT_BY_KEY_UNIT_MACROS_SVH
`define LOMUTO_QUICKSORT_BY_KEY_UNIT_MACROS_SVH
`define LQS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/lqs_pkg.sv @@
// shared types and constants for the quicksort unit
// no dependencies
package lqs_pkg;
    localparam int KEY_W = 16;
    localparam int TAG_W = 6;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef struct packed {
        key_t key;
        tag_t tag;
    } rec_t;
endpackage

@@ design/lomuto_quicksort_by_key_unit.sv @@
// Collects up to DEPTH records (one item a cycle) until one marked last, sorts
// them by key with Lomuto quicksort over a record memory and a range stack,
// then emits them in ascending order. Each range is handled as a pop, a pivot
// read, a scan of its entries ending in a final compare, a final swap and the
// pushes; an entry that stays costs only its compare, while an entry swapped
// forward also needs a read-modify-write of two entries over the one memory
// read port, so the sort runs slowest when the keys are already in order. Each
// record is then read and emitted in turn; s_tready is low meanwhile.
// depends on lqs_pkg, lqs_rec_mem, lqs_stack_mem
module lomuto_quicksort_by_key_unit #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // exec_time[15:0], tag[21:16], zero fill
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sorted_time[15:0], sorted_tag[21:16], zero fill
    output logic        m_tlast,   // final_out
    output logic        m_tuser    // overflowed
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SD = (DEPTH / 2 > 1) ? DEPTH / 2 : 2;
    localparam int SW = $clog2(SD);
    localparam int RW = 2 * AW;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_POP   = 14'b00000000000010,
        S_POPW  = 14'b00000000000100,
        S_PIV   = 14'b00000000001000,
        S_SRD   = 14'b00000000010000,
        S_SCMP  = 14'b00000000100000,
        S_SWA   = 14'b00000001000000,
        S_SWB   = 14'b00000010000000,
        S_FRD   = 14'b00000100000000,
        S_FSWA  = 14'b00001000000000,
        S_FSWB  = 14'b00010000000000,
        S_HI    = 14'b00100000000000,
        S_ORD   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] st_reg, st_next, sc_reg, sc_next;
    logic [SW:0] sp_reg, sp_next;
    lqs_pkg::key_t piv_reg, piv_next;
    lqs_pkg::rec_t a_reg, a_next;
    logic [CW-1:0] oi_reg, oi_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    lqs_pkg::rec_t wdata, rdata;
    logic swe;
    logic [SW-1:0] swaddr, sraddr;
    logic [RW-1:0] swdata, srdata;

    lqs_rec_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    lqs_stack_mem #(.SD(SD), .SW(SW), .DW(RW)) u_stk (
        .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
        .raddr(sraddr), .rdata(srdata)
    );

    logic [AW-1:0] p_lo, p_hi;
    assign p_lo = srdata[AW-1:0];
    assign p_hi = srdata[RW-1:AW];

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {2'b00, rdata.tag, rdata.key};
    assign m_tlast = ({1'b0, oi_reg} + 1'b1) == {1'b0, cnt_reg};
    assign m_tuser = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        st_next = st_reg;
        sc_next = sc_reg;
        sp_next = sp_reg;
        piv_next = piv_reg;
        a_next = a_reg;
        oi_next = oi_reg;
        we = 1'b0;
        waddr = cnt_reg[AW-1:0];
        wdata = '{key: s_tdata[15:0], tag: s_tdata[21:16]};
        raddr = sc_reg;
        swe = 1'b0;
        swaddr = sp_reg[SW-1:0];
        swdata = '0;
        sraddr = sp_reg[SW-1:0] - 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (cnt_reg < CW'(DEPTH))
                    begin
                        we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        if (cnt_next >= CW'(2))
                        begin
                            swe = 1'b1;
                            swaddr = '0;
                            swdata = {AW'(cnt_next - 1'b1), AW'(0)};
                            sp_next = (SW+1)'(1);
                            state_next = S_POP;
                        end
                        else
                        begin
                            oi_next = '0;
                            state_next = S_ORD;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    oi_next = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next = p_lo;
                hi_next = p_hi;
                st_next = p_lo;
                sc_next = p_lo;
                raddr = p_hi;
                state_next = S_PIV;
            end
            S_PIV:
            begin
                piv_next = rdata.key;
                a_next = rdata;
                raddr = sc_reg;
                state_next = S_SCMP;
            end
            S_SRD:
            begin
                raddr = sc_reg;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (sc_reg == hi_reg)
                begin
                    raddr = st_reg;
                    state_next = S_FRD;
                end
                else if (rdata.key <= piv_reg)
                begin
                    a_next = rdata;
                    raddr = st_reg;
                    state_next = S_SWA;
                end
                else
                begin
                    sc_next = sc_reg + 1'b1;
                    raddr = sc_next;
                    state_next = S_SCMP;
                end
            end
            S_SWA:
            begin
                we = 1'b1;
                waddr = sc_reg;
                wdata = rdata;
                state_next = S_SWB;
            end
            S_SWB:
            begin
                we = 1'b1;
                waddr = st_reg;
                wdata = a_reg;
                st_next = st_reg + 1'b1;
                sc_next = sc_reg + 1'b1;
                state_next = S_SRD;
            end
            S_FRD:
            begin
                a_next = rdata;
                raddr = hi_reg;
                state_next = S_FSWA;
            end
            S_FSWA:
            begin
                we = 1'b1;
                waddr = st_reg;
                wdata = rdata;
                state_next = S_FSWB;
            end
            S_FSWB:
            begin
                we = 1'b1;
                waddr = hi_reg;
                wdata = a_reg;
                if ((st_reg > lo_reg) && (st_reg - 1'b1 > lo_reg))
                begin
                    swe = 1'b1;
                    swaddr = sp_reg[SW-1:0];
                    swdata = {AW'(st_reg - 1'b1), lo_reg};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_HI;
            end
            S_HI:
            begin
                if (st_reg < hi_reg && (st_reg + 1'b1) < hi_reg)
                begin
                    swe = 1'b1;
                    swaddr = sp_reg[SW-1:0];
                    swdata = {hi_reg, AW'(st_reg + 1'b1)};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_POP;
            end
            S_ORD:
            begin
                raddr = oi_reg[AW-1:0];
                if (cnt_reg == '0)
                begin
                    ovf_next = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                raddr = oi_reg[AW-1:0];
                if (m_tready)
                begin
                    if (m_tlast)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        oi_next = oi_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sp_reg <= '0;
            oi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            sp_reg <= sp_next;
            oi_reg <= oi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        st_reg <= st_next;
        sc_reg <= sc_next;
        piv_reg <= piv_next;
        a_reg <= a_next;
    end
endmodule

@@ design/lqs_rec_mem.sv @@
// record memory, one write and one read port, registered read data
// depends on lqs_pkg
module lqs_rec_mem #(
    parameter int DEPTH = 32,
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  lqs_pkg::rec_t wdata,
    input  logic [AW-1:0] raddr,
    output lqs_pkg::rec_t rdata
);
    lqs_pkg::rec_t mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/lqs_stack_mem.sv @@
// range stack memory, registered read data
// depends on nothing
module lqs_stack_mem #(
    parameter int SD = 16,
    parameter int SW = 4,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [SW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [SD];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/lqs_checker.sv @@
// port-level checks for the quicksort unit, bound to the top level
// depends on lomuto_quicksort_by_key_unit_macros.svh
`include "lomuto_quicksort_by_key_unit_macros.svh"
module lqs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    `LQS_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready)
    `LQS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LQS_ASSERT_NEXT(a_last_reopens, m_tvalid && m_tready && m_tlast, s_tready)
    `LQS_ASSERT_NEXT(a_ovf_steady, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || $stable(m_tuser))
endmodule

bind lomuto_quicksort_by_key_unit lqs_checker u_lqs_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
);

@@ dv/lomuto_quicksort_by_key_unit_tb.sv @@
// testbench for lomuto_quicksort_by_key_unit: loads record sets, predicts the sorted
// output with its own lomuto quicksort and compares every emitted record
// depends on lqs_pkg and the unit rtl
module lomuto_quicksort_by_key_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    typedef struct {
        lqs_pkg::key_t key;
        lqs_pkg::tag_t tag;
        logic fin;
        logic ovf;
    } sorted_rec_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    sorted_rec_t   sorted_q[$];
    lqs_pkg::key_t set_keys[DEPTH];
    lqs_pkg::tag_t set_tags[DEPTH];
    int          set_count;
    logic        set_ovf;
    int          fail_count;
    int          item_total;
    int          result_total;
    int          set_total;
    bit          src_idle_en;
    bit          snk_idle_en;
    int          hold_cycles;

    lomuto_quicksort_by_key_unit #(.DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic swap_recs(int a, int b);
        lqs_pkg::key_t k;
        lqs_pkg::tag_t t;
        k = set_keys[a];
        t = set_tags[a];
        set_keys[a] = set_keys[b];
        set_tags[a] = set_tags[b];
        set_keys[b] = k;
        set_tags[b] = t;
    endtask

    task automatic sort_and_predict();
        int   lo_st[$];
        int   hi_st[$];
        int   lo;
        int   hi;
        int   pos;
        lqs_pkg::key_t pv;
        sorted_rec_t r;
        if (set_count > 1)
        begin
            lo_st.push_back(0);
            hi_st.push_back(set_count - 1);
        end
        while (lo_st.size() > 0)
        begin
            lo = lo_st.pop_back();
            hi = hi_st.pop_back();
            pv = set_keys[hi];
            pos = lo;
            for (int s = lo; s < hi; s++)
                if (set_keys[s] <= pv)
                begin
                    swap_recs(pos, s);
                    pos++;
                end
            swap_recs(pos, hi);
            if (pos > lo + 1)
            begin
                lo_st.push_back(lo);
                hi_st.push_back(pos - 1);
            end
            if (pos + 1 < hi)
            begin
                lo_st.push_back(pos + 1);
                hi_st.push_back(hi);
            end
        end
        for (int k = 0; k < set_count; k++)
        begin
            r.key = set_keys[k];
            r.tag = set_tags[k];
            r.fin = (k == set_count - 1);
            r.ovf = set_ovf;
            sorted_q.push_back(r);
        end
        set_count = 0;
        set_ovf = 1'b0;
        set_total++;
    endtask

    task automatic send_rec(lqs_pkg::key_t key, lqs_pkg::tag_t tag, logic last);
        while (src_idle_en && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, tag, key};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_total++;
        if (set_count < DEPTH)
        begin
            set_keys[set_count] = key;
            set_tags[set_count] = tag;
            set_count++;
        end
        else
            set_ovf = 1'b1;
        if (last)
            sort_and_predict();
    endtask

    task automatic send_set(int n, int kind);
        lqs_pkg::key_t k;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: k = lqs_pkg::key_t'($urandom);
                1: k = lqs_pkg::key_t'($urandom_range(3));
                2: k = lqs_pkg::key_t'(i * 100);
                default: k = lqs_pkg::key_t'((n - i) * 7);
            endcase
            send_rec(k, lqs_pkg::tag_t'($urandom), i == n - 1);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (sorted_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_extremes();
        send_rec(16'hFFFF, 6'h3F, 1'b1);
        send_rec(16'h0000, 6'h00, 1'b0);
        send_rec(16'hFFFF, 6'h3F, 1'b0);
        send_rec(16'h0000, 6'h2A, 1'b1);
        send_rec(16'h5555, 6'h15, 1'b0);
        send_rec(16'hAAAA, 6'h2A, 1'b0);
        send_rec(16'h5555, 6'h01, 1'b1);
    endtask

    task automatic test_full_and_overflow();
        send_set(DEPTH, 0);
        send_set(DEPTH + 3, 1);
        send_set(DEPTH + 1, 0);
    endtask

    task automatic test_random_sets();
        int n;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_set(12, 2);
        send_set(12, 3);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        while (item_total < 210)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 4, 1) : $urandom_range(10, 1);
            send_set(n, $urandom_range(3));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        send_set(8, 0);
        send_set(6, 1);
        send_set(5, 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(snk_idle_en && $urandom_range(99) < 28);
    end

    always @(posedge clk)
    begin
        sorted_rec_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_total++;
            if (sorted_q.size() == 0)
            begin
                $error("unexpected result time=%h", m_tdata[15:0]);
                fail_count++;
            end
            else
            begin
                e = sorted_q.pop_front();
                if (m_tdata[15:0] !== e.key)
                begin
                    $error("sorted_time exp %h got %h", e.key, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[21:16] !== e.tag)
                begin
                    $error("sorted_tag exp %h got %h", e.tag, m_tdata[21:16]);
                    fail_count++;
                end
                if (m_tlast !== e.fin)
                begin
                    $error("final_out exp %b got %b", e.fin, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== e.ovf)
                begin
                    $error("overflowed exp %b got %b", e.ovf, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        fail_count = 0;
        item_total = 0;
        result_total = 0;
        set_total = 0;
        set_count = 0;
        set_ovf = 1'b0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        hold_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_full_and_overflow();
        test_backpressure();
        test_random_sets();
        wait_drained();
        $display("sent %0d items in %0d sets, checked %0d sorted records",
                 item_total, set_total, result_total);
        if (fail_count == 0 && sorted_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
